// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while the reset is high.
`define ASSERT_DIS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent check that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: src/ssec_pkg.sv
// Shared constants and token type of the subarray sum counter.
package ssec_pkg;

   localparam int MAX_LEN     = 1023;
   localparam int TABLE_DEPTH = MAX_LEN + 1;
   localparam int NUM_CELLS   = TABLE_DEPTH;
   localparam int SEEN_W      = $clog2(MAX_LEN + 1);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ELEM_W      = 16;
   localparam int KEY_W       = 26;
   localparam int LOOK_W      = KEY_W + 1;
   localparam int TOTAL_W     = 19;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [TOTAL_W-1:0]    COUNT_MAX       = {TOTAL_W{1'b1}};
   localparam logic [CSR_ADDR_W-1:0] ADDR_TARGET_SUM = 3'd0;

   typedef struct packed {
      logic              valid;
      logic              active;
      logic              last;
      logic              ovf;
      logic              hit;
      logic [KEY_W-1:0]  key_upd;
      logic [LOOK_W-1:0] key_look;
      logic [CNT_W-1:0]  acc;
   } ssec_token_type;

endpackage

// File: src/ssec_cell.sv
// One table cell: holds a prefix key and its count and passes the token on.
module ssec_cell import ssec_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           seed,
   input  ssec_token_type up_tok,
   output ssec_token_type down_tok
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   ssec_token_type   tok_ff, tok_in;
   logic             look_hit;
   logic             upd_hit;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      cnt_in   = cnt_ff;
      tok_in   = up_tok;
      look_hit = valid_ff && ({key_ff[KEY_W-1], key_ff} == up_tok.key_look);
      upd_hit  = valid_ff && (key_ff == up_tok.key_upd);
      if (up_tok.valid && up_tok.active) begin
         if (look_hit) begin
            tok_in.acc = cnt_ff;
         end
         if (!up_tok.hit) begin
            if (upd_hit) begin
               cnt_in     = cnt_ff + CNT_W'(1);
               tok_in.hit = 1'b1;
            end else if (!valid_ff) begin
               valid_in   = 1'b1;
               key_in     = up_tok.key_upd;
               cnt_in     = CNT_W'(1);
               tok_in.hit = 1'b1;
            end
         end
      end
      if (up_tok.valid && up_tok.last) begin
         valid_in = seed;
         key_in   = '0;
         cnt_in   = seed ? CNT_W'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= seed;
         key_ff   <= '0;
         cnt_ff   <= seed ? CNT_W'(1) : '0;
         tok_ff   <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
         key_ff   <= key_in;
         cnt_ff   <= cnt_in;
         tok_ff   <= tok_in;
      end
   end

   assign down_tok = tok_ff;

endmodule

// File: src/ssec_feed.sv
// Entry stage: running prefix, length limit and token build.
module ssec_feed import ssec_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              accept,
   input  logic [ELEM_W-1:0] element,
   input  logic              is_last,
   input  logic [KEY_W-1:0]  target,
   output ssec_token_type    tok_out
);

   logic [KEY_W-1:0]  prefix_ff, prefix_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic              ovf_ff, ovf_in;
   ssec_token_type    tok_ff, tok_in;
   logic              ovf_now;
   logic [KEY_W-1:0]  sum;

   always_comb begin
      ovf_now = ovf_ff || (seen_ff >= SEEN_W'(MAX_LEN));
      sum     = prefix_ff + {{(KEY_W-ELEM_W){element[ELEM_W-1]}}, element};

      tok_in          = '0;
      tok_in.valid    = accept;
      tok_in.active   = !ovf_now;
      tok_in.last     = is_last;
      tok_in.ovf      = ovf_now;
      tok_in.key_upd  = sum;
      tok_in.key_look = {sum[KEY_W-1], sum} - {target[KEY_W-1], target};

      prefix_in = prefix_ff;
      seen_in   = seen_ff;
      ovf_in    = ovf_ff;
      if (accept) begin
         if (is_last) begin
            prefix_in = '0;
            seen_in   = '0;
            ovf_in    = 1'b0;
         end else begin
            ovf_in = ovf_now;
            if (!ovf_now) begin
               prefix_in = sum;
               seen_in   = seen_ff + SEEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         seen_ff   <= '0;
         ovf_ff    <= 1'b0;
         tok_ff    <= '0;
      end else if (advance) begin
         prefix_ff <= prefix_in;
         seen_ff   <= seen_in;
         ovf_ff    <= ovf_in;
         tok_ff    <= tok_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

// File: src/ssec_tally.sv
// Tail stage: running match total and the result register.
module ssec_tally import ssec_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ssec_token_type         tok,
   input  logic                   rsp_tready,
   output logic                   advance,
   output logic                   rsp_tvalid,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [18:0] match_count
   output logic                   rsp_tlast,
   output logic                   rsp_tuser    // [0] overflow
);

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [TOTAL_W-1:0] count_ff;
   logic               valid_ff, last_ff, ovf_ff;
   logic [TOTAL_W:0]   sum;
   logic [TOTAL_W-1:0] new_total;

   always_comb begin
      advance   = !valid_ff || rsp_tready;
      sum       = {1'b0, total_ff} + (TOTAL_W+1)'(tok.acc);
      new_total = total_ff;
      if (tok.active) begin
         new_total = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[TOTAL_W-1:0];
      end
      total_in = tok.last ? '0 : new_total;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         total_ff <= '0;
      end else if (advance) begin
         valid_ff <= tok.valid;
         if (tok.valid) begin
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tok.valid) begin
         count_ff <= new_total;
         last_ff  <= tok.last;
         ovf_ff   <= tok.ovf;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-TOTAL_W){1'b0}}, count_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = ovf_ff;

endmodule

// File: src/subarray_sum_equals_target_counter_core.sv
// Top level of the subarray sum counter: register port, entry stage, cell chain, tail.
// Each transfer passes an entry register, one register per table cell (1024) and the
// result register.
// One item is taken every cycle unless a stalled result holds the whole chain.
// Reset clears the prefix, the total and target_sum and leaves only cell 0 seeded.
// The table reseeds itself as the closing element of an array passes each cell.
module subarray_sum_equals_target_counter_core import ssec_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [ELEM_W-1:0]     req_tdata,    // [15:0] element
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [18:0] match_count
   output logic                  rsp_tlast,
   output logic                  rsp_tuser,    // [0] overflow
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [KEY_W-1:0] target_ff;
   logic             advance;
   ssec_token_type   tok_chain [0:NUM_CELLS];

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_TARGET_SUM) begin
         target_ff <= csr_pwdata[KEY_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == ADDR_TARGET_SUM) begin
         csr_prdata = {{(CSR_DATA_W-KEY_W){target_ff[KEY_W-1]}}, target_ff};
      end
   end

   assign req_tready = advance;

   ssec_feed u_feed (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .accept  (req_tvalid && advance),
      .element (req_tdata),
      .is_last (req_tlast),
      .target  (target_ff),
      .tok_out (tok_chain[0])
   );

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      ssec_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .seed     (i == 0),
         .up_tok   (tok_chain[i]),
         .down_tok (tok_chain[i+1])
      );
   end

   ssec_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .tok        (tok_chain[NUM_CELLS]),
      .rsp_tready (rsp_tready),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: src/ssec_checker.sv
// Port-level checks of the subarray sum counter and their binding.
`include "assert_macros.svh"

module ssec_checker import ssec_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [ELEM_W-1:0]      req_tdata,
   input logic                   req_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic                   rsp_tlast,
   input logic                   rsp_tuser,
   input logic                   csr_psel,
   input logic                   csr_penable,
   input logic                   csr_pwrite,
   input logic [CSR_ADDR_W-1:0]  csr_paddr,
   input logic [CSR_DATA_W-1:0]  csr_pwdata,
   input logic [CSR_DATA_W-1:0]  csr_prdata,
   input logic                   csr_pready
);

   logic                   rsp_stall;
   logic [RSP_TDATA_W+1:0] rsp_word;
   logic                   target_write;
   logic                   target_read;
   logic                   readback_due;
   logic [KEY_W-1:0]       rd_value;
   logic                   wrote_ff;
   logic [KEY_W-1:0]       wval_ff;

   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_word     = {rsp_tuser, rsp_tlast, rsp_tdata};
   assign target_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                         && (csr_paddr == ADDR_TARGET_SUM);
   assign target_read  = csr_paddr == ADDR_TARGET_SUM;
   assign readback_due = wrote_ff && target_read;
   assign rd_value     = csr_prdata[KEY_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         wrote_ff <= 1'b0;
      end else begin
         wrote_ff <= target_write;
      end
      wval_ff <= csr_pwdata[KEY_W-1:0];
   end

   `ASSERT_ALWAYS(a_no_rsp_after_reset, clock, $past(reset) |-> !rsp_tvalid)

   `ASSERT_DIS(a_stall_holds_input, clock, reset, rsp_stall |-> !req_tready)

   `ASSERT_DIS(a_rsp_stable, clock, reset, rsp_stall |=> (rsp_tvalid && $stable(rsp_word)))

   `ASSERT_DIS(a_pad_zero, clock, reset, rsp_tvalid |-> (rsp_tdata[RSP_TDATA_W-1:TOTAL_W] == '0))

   `ASSERT_DIS(a_target_readback, clock, reset, readback_due |-> (rd_value == wval_ff))

endmodule

bind subarray_sum_equals_target_counter_core ssec_checker u_ssec_checker (.*);

// File: dv/subarray_sum_equals_target_counter_core_tb.sv
// Self-checking testbench for the subarray sum counter core with a built-in prediction of its counts.
module subarray_sum_equals_target_counter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ssec_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int END_WAIT    = 1100;
   localparam int HOLD_CYCLES = 1500;
   localparam logic signed [KEY_W-1:0] TARGET_TOP    = {1'b0, {(KEY_W-1){1'b1}}};
   localparam logic signed [KEY_W-1:0] TARGET_BOTTOM = {1'b1, {(KEY_W-1){1'b0}}};

   typedef struct packed {
      logic [TOTAL_W-1:0] count;
      logic               last;
      logic               ovf;
   } sum_result_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ELEM_W-1:0]      req_tdata;    // [15:0] element
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;    // [18:0] match_count, [23:19] zero
   logic                   rsp_tlast;
   logic                   rsp_tuser;    // [0] overflow
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   logic signed [KEY_W-1:0] target_q;
   logic signed [KEY_W-1:0] prefix_q;
   int unsigned             total_q;
   int unsigned             seen_q;
   bit                      ovf_q;
   int unsigned             prefix_tally [longint];

   sum_result_type pending_sums [$];
   int  error_count;
   int  elements_sent;
   int  arrays_sent;
   int  targets_written;
   int  results_checked;
   int  input_stall_cycles;
   int  cycle_count;
   bit  feed_idles;
   bit  drain_idles;
   int  sink_hold_req;

   subarray_sum_equals_target_counter_core DUT (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   function automatic void restart_array();
      prefix_q = '0;
      total_q  = 0;
      seen_q   = 0;
      ovf_q    = 1'b0;
      prefix_tally.delete();
      prefix_tally[0] = 1;
   endfunction

   function automatic sum_result_type advance_prefix_sum(logic signed [ELEM_W-1:0] elem,
                                                         logic last);
      sum_result_type res;
      longint         probe;
      if (!ovf_q && seen_q >= MAX_LEN) ovf_q = 1'b1;
      if (!ovf_q) begin
         prefix_q = prefix_q + elem;
         seen_q++;
         probe = longint'(prefix_q) - longint'(target_q);
         if (prefix_tally.exists(probe)) begin
            total_q = total_q + prefix_tally[probe];
            if (total_q > COUNT_MAX) total_q = COUNT_MAX;
         end
         if (prefix_tally.exists(longint'(prefix_q))) prefix_tally[longint'(prefix_q)]++;
         else prefix_tally[longint'(prefix_q)] = 1;
      end
      res.count = TOTAL_W'(total_q);
      res.last  = last;
      res.ovf   = ovf_q;
      if (last) restart_array();
      return res;
   endfunction

   function automatic int idle_len();
      if ($urandom_range(0, 15) == 0) return $urandom_range(20, 80);
      return $urandom_range(1, 3);
   endfunction

   task automatic push_element(input logic signed [ELEM_W-1:0] elem, input logic last);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= elem;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         input_stall_cycles++;
         @(posedge clock);
      end
      pending_sums.push_back(advance_prefix_sum(elem, last));
      elements_sent++;
      if (last) arrays_sent++;
      if (feed_idles && $urandom_range(0, 2) == 0) begin
         gap = idle_len();
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= ADDR_TARGET_SUM;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic check_target_readback();
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, '0, rdata);
      if (rdata[KEY_W-1:0] !== target_q)
         report_mismatch($sformatf("target_sum read %0d, expected %0d",
                                   $signed(rdata[KEY_W-1:0]), target_q));
   endtask

   task automatic set_target(input logic signed [KEY_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, CSR_DATA_W'(value), rdata);
      target_q = value;
      targets_written++;
      check_target_readback();
   endtask

   function automatic logic signed [ELEM_W-1:0] pick_element();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return ELEM_W'($urandom_range(0, 8)) - 16'sd4;
      if (r < 17) return ELEM_W'($urandom());
      if (r == 17) return 16'sh7FFF;
      if (r == 18) return 16'sh8000;
      return ELEM_W'(target_q);
   endfunction

   task automatic test_reset_state();
      check_target_readback();
      push_element(16'sd0, 1'b1);
      push_element(16'sh7FFF, 1'b0);
      push_element(16'sh8000, 1'b0);
      push_element(16'sd1, 1'b1);
      push_element(16'sh8000, 1'b0);
      push_element(16'sh8000, 1'b0);
      push_element(16'sh7FFF, 1'b0);
      push_element(16'sh7FFF, 1'b1);
      wait_drained();
   endtask

   task automatic test_target_extremes();
      set_target(TARGET_TOP);
      push_element(16'sh7FFF, 1'b0);
      push_element(16'sh7FFF, 1'b1);
      wait_drained();
      set_target(TARGET_BOTTOM);
      push_element(16'sh8000, 1'b0);
      push_element(16'sd0, 1'b1);
      wait_drained();
   endtask

   task automatic test_matches_and_close();
      set_target(26'sd5);
      push_element(16'sd5, 1'b1);
      push_element(16'sd5, 1'b1);
      push_element(16'sd2, 1'b0);
      push_element(16'sd3, 1'b1);
      push_element(16'sd5, 1'b0);
      push_element(-16'sd5, 1'b0);
      push_element(16'sd5, 1'b0);
      push_element(-16'sd5, 1'b1);
      wait_drained();
      set_target(-26'sd1);
      push_element(-16'sd1, 1'b0);
      push_element(16'sd0, 1'b0);
      push_element(16'sd1, 1'b0);
      push_element(-16'sd1, 1'b1);
      wait_drained();
   endtask

   // A full-length array of zeros reaches the largest count, the extra elements
   // run past the table, and the output is held off long enough to fill the chain.
   task automatic test_full_array_and_overflow();
      set_target(26'sd0);
      feed_idles    = 1'b0;
      drain_idles   = 1'b0;
      sink_hold_req = HOLD_CYCLES;
      repeat (MAX_LEN) push_element(16'sd0, 1'b0);
      repeat (7) push_element(pick_element(), 1'b0);
      push_element(pick_element(), 1'b1);
      push_element(16'sd1, 1'b0);
      push_element(-16'sd1, 1'b0);
      push_element(16'sd0, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_arrays(input int per_target);
      logic signed [KEY_W-1:0] targets [7];
      int goal;
      int len;
      int r;
      targets[0] = 26'sd0;
      targets[1] = 26'sd3;
      targets[2] = -26'sd4;
      targets[3] = KEY_W'($urandom_range(0, 12)) - 26'sd6;
      targets[4] = TARGET_TOP;
      targets[5] = TARGET_BOTTOM;
      targets[6] = KEY_W'($urandom());
      for (int k = 0; k < 7; k++) begin
         set_target(targets[k]);
         feed_idles  = (k % 3) != 2;
         drain_idles = (k % 3) != 1;
         goal = elements_sent + per_target;
         while (elements_sent < goal) begin
            r = $urandom_range(0, 9);
            if (r < 6) len = $urandom_range(1, 10);
            else if (r < 9) len = $urandom_range(11, 40);
            else len = $urandom_range(41, 150);
            for (int i = 1; i <= len; i++) push_element(pick_element(), i == len);
         end
         wait_drained();
      end
   endtask

   initial begin : sink_proc
      int stall_left;
      stall_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_hold_req != 0) begin
            stall_left    = sink_hold_req;
            sink_hold_req = 0;
         end else if (stall_left == 0 && drain_idles && $urandom_range(0, 3) == 0) begin
            stall_left = idle_len();
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      sum_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_sums.size() == 0) begin
            report_mismatch("result transfer with no element pending");
         end else begin
            want = pending_sums.pop_front();
            if (rsp_tdata !== RSP_TDATA_W'(want.count))
               report_mismatch($sformatf("result %0d: match count %0d, expected %0d",
                                         results_checked, rsp_tdata, want.count));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("result %0d: last flag %b, expected %b",
                                         results_checked, rsp_tlast, want.last));
            if (rsp_tuser !== want.ovf)
               report_mismatch($sformatf("result %0d: overflow flag %b, expected %b",
                                         results_checked, rsp_tuser, want.ovf));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending",
                  cycle_count, pending_sums.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      error_count        = 0;
      elements_sent      = 0;
      arrays_sent        = 0;
      targets_written    = 0;
      results_checked    = 0;
      input_stall_cycles = 0;
      cycle_count        = 0;
      sink_hold_req      = 0;
      feed_idles         = 1'b1;
      drain_idles        = 1'b1;
      target_q           = '0;
      restart_array();
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_target_extremes();
      test_matches_and_close();
      test_full_array_and_overflow();
      test_random_arrays(110);

      wait_drained();
      repeat (END_WAIT) @(posedge clock);
      $display("Sent %0d elements in %0d arrays under %0d target settings; %0d results checked.",
               elements_sent, arrays_sent, targets_written, results_checked);
      $display("Input was stalled for %0d cycles while the output was held off.",
               input_stall_cycles);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/ssec_pkg.sv
src/ssec_cell.sv
src/ssec_feed.sv
src/ssec_tally.sv
src/subarray_sum_equals_target_counter_core.sv
src/ssec_checker.sv
dv/subarray_sum_equals_target_counter_core_tb.sv
